// ===== hdl/kdaq_pkg.sv =====
// Shared types, constants and the key encoder for the keypad debounce and repeat queue.
// Used by every module of the block; depends on nothing else.
package kdaq_pkg;

   // Ring queue geometry. One slot is always kept free.
   localparam int QUEUE_SLOTS = 6;
   localparam int PTR_W       = (QUEUE_SLOTS > 2) ? $clog2(QUEUE_SLOTS) : 1;

   localparam int CODE_W  = 3;
   localparam int COUNT_W = 3;
   localparam int TICKS_W = 8;
   localparam int LINES_W = 7;
   localparam int KIND_W  = 2;
   localparam int CSR_IDX_W = 2;

   // Request kinds carried in tuser.
   localparam logic [KIND_W-1:0] REQ_TICK  = 2'd0;
   localparam logic [KIND_W-1:0] REQ_POP   = 2'd1;
   localparam logic [KIND_W-1:0] REQ_FLUSH = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT   = 2'd2;

   localparam logic [TICKS_W-1:0] DEBOUNCE_RESET = 8'd3;
   localparam logic [TICKS_W-1:0] DELAY_RESET    = 8'd50;
   localparam logic [TICKS_W-1:0] REPEAT_RESET   = 8'd15;

   localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;
   localparam logic [CODE_W-1:0] CODE_RUN  = 3'd7;

   typedef logic [CODE_W-1:0]  code_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [PTR_W-1:0]   ptr_type;
   typedef logic [TICKS_W-1:0] ticks_type;

   // Code for each key line, lowest line has the highest priority.
   typedef code_type key_codes_type [LINES_W];
   localparam key_codes_type KEY_CODES = '{3'd5, 3'd6, 3'd7, 3'd4, 3'd3, 3'd2, 3'd1};

   typedef enum logic [3:0] {
      PH_WAIT     = 4'b0001,
      PH_DEBOUNCE = 4'b0010,
      PH_DELAY    = 4'b0100,
      PH_REPEAT   = 4'b1000
   } phase_type;

   typedef struct packed {
      ticks_type debounce_ticks;
      ticks_type initial_delay_ticks;
      ticks_type repeat_ticks;
   } cfg_type;

   typedef struct packed {
      logic     valid;
      code_type code;
   } offer_type;

   typedef struct packed {
      logic pop;
      logic flush;
   } queue_cmd_type;

   typedef struct packed {
      code_type  popped_code;
      count_type queued_count;
      logic      stop_flag;
   } status_type;

   // Priority encoder over the active-low key lines; no line low gives code zero.
   function automatic code_type encode_keys(input logic [LINES_W-1:0] lines);
      code_type code;
      code = CODE_NONE;
      for (int i = LINES_W - 1; i >= 0; i--) begin
         if (!lines[i]) begin
            code = KEY_CODES[i];
         end
      end
      return code;
   endfunction

   function automatic ptr_type next_slot(input ptr_type p);
      return (p == ptr_type'(QUEUE_SLOTS - 1)) ? '0 : p + ptr_type'(1);
   endfunction

endpackage

// ===== hdl/kdaq_keyfsm.sv =====
// Debounce, initial delay and auto-repeat phase machine for the sampled keypad.
// Depends on kdaq_pkg; emits one queue offer per tick that calls for it.
module kdaq_keyfsm
   import kdaq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tick_en,
   input  logic [LINES_W-1:0]   key_lines,
   input  cfg_type              cfg,
   output offer_type            offer
);

   phase_type phase_ff, phase_in;
   code_type  held_code_ff, held_code_in;
   ticks_type debounce_count_ff, debounce_count_in;
   ticks_type delay_count_ff, delay_count_in;
   ticks_type repeat_count_ff, repeat_count_in;

   code_type  code;
   ticks_type debounce_inc, delay_inc, repeat_inc;

   assign code         = encode_keys(key_lines);
   assign debounce_inc = debounce_count_ff + ticks_type'(1);
   assign delay_inc    = delay_count_ff + ticks_type'(1);
   assign repeat_inc   = repeat_count_ff + ticks_type'(1);

   always_comb begin
      phase_in          = phase_ff;
      held_code_in      = held_code_ff;
      debounce_count_in = debounce_count_ff;
      delay_count_in    = delay_count_ff;
      repeat_count_in   = repeat_count_ff;
      offer.valid       = 1'b0;
      offer.code        = held_code_ff;
      if (tick_en) begin
         unique case (phase_ff)
            PH_WAIT: begin
               debounce_count_in = '0;
               if (code != CODE_NONE) begin
                  held_code_in = code;
                  phase_in     = PH_DEBOUNCE;
               end
            end
            PH_DEBOUNCE: begin
               if (code != held_code_ff) begin
                  phase_in = PH_WAIT;
               end else begin
                  debounce_count_in = debounce_inc;
                  if (debounce_inc >= cfg.debounce_ticks) begin
                     delay_count_in = '0;
                     phase_in       = PH_DELAY;
                  end
               end
            end
            PH_DELAY: begin
               if (code != held_code_ff) begin
                  // A release during the delay counts as a short press.
                  offer.valid = (code == CODE_NONE);
                  phase_in    = PH_WAIT;
               end else begin
                  delay_count_in = delay_inc;
                  if (delay_inc >= cfg.initial_delay_ticks) begin
                     offer.valid     = 1'b1;
                     repeat_count_in = '0;
                     phase_in        = PH_REPEAT;
                  end
               end
            end
            PH_REPEAT: begin
               if (code != held_code_ff) begin
                  phase_in = PH_WAIT;
               end else begin
                  repeat_count_in = repeat_inc;
                  if (repeat_inc >= cfg.repeat_ticks) begin
                     offer.valid     = 1'b1;
                     repeat_count_in = '0;
                  end
               end
            end
            default: begin
               phase_in = PH_WAIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff          <= PH_WAIT;
         held_code_ff      <= CODE_NONE;
         debounce_count_ff <= '0;
         delay_count_ff    <= '0;
         repeat_count_ff   <= '0;
      end else begin
         phase_ff          <= phase_in;
         held_code_ff      <= held_code_in;
         debounce_count_ff <= debounce_count_in;
         delay_count_ff    <= delay_count_in;
         repeat_count_ff   <= repeat_count_in;
      end
   end

endmodule

// ===== hdl/kdaq_queue.sv =====
// Ring queue of key codes with one slot kept free, plus the sticky stop flag.
// Depends on kdaq_pkg; reports the status that goes into each result beat.
module kdaq_queue
   import kdaq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  queue_cmd_type cmd,
   input  offer_type     offer,
   output status_type    status
);

   code_type code_slots [QUEUE_SLOTS];

   ptr_type read_ptr_ff, read_ptr_in;
   ptr_type write_ptr_ff, write_ptr_in;
   logic    stop_seen_ff, stop_seen_in;

   ptr_type          write_next;
   logic             slot_write;
   logic             not_empty;
   logic [PTR_W:0]   diff;
   ptr_type          count;
   code_type         pop_code;

   assign write_next = next_slot(write_ptr_ff);
   assign not_empty  = (read_ptr_ff != write_ptr_ff);
   assign slot_write = offer.valid && (write_next != read_ptr_ff);

   always_comb begin
      read_ptr_in  = read_ptr_ff;
      write_ptr_in = write_ptr_ff;
      stop_seen_in = stop_seen_ff;
      pop_code     = CODE_NONE;
      if (offer.valid) begin
         // The run key stops the program even when its code cannot be stored.
         if (offer.code == CODE_RUN) begin
            stop_seen_in = 1'b1;
         end
         if (slot_write) begin
            write_ptr_in = write_next;
         end
      end
      if (cmd.pop && not_empty) begin
         pop_code    = code_slots[read_ptr_ff];
         read_ptr_in = next_slot(read_ptr_ff);
      end
      if (cmd.flush) begin
         read_ptr_in  = write_ptr_ff;
         stop_seen_in = 1'b0;
      end
   end

   // Fill level after this beat; the difference stays below twice the slot count.
   always_comb begin
      diff = {1'b0, write_ptr_in} - {1'b0, read_ptr_in};
      if (write_ptr_in < read_ptr_in) begin
         diff = diff + (PTR_W + 1)'(QUEUE_SLOTS);
      end
      count = diff[PTR_W-1:0];
   end

   assign status = {pop_code, count_type'(count), stop_seen_in};

   always_ff @(posedge clock) begin
      if (slot_write) begin
         code_slots[write_ptr_ff] <= offer.code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         read_ptr_ff  <= '0;
         write_ptr_ff <= '0;
         stop_seen_ff <= 1'b0;
      end else begin
         read_ptr_ff  <= read_ptr_in;
         write_ptr_ff <= write_ptr_in;
         stop_seen_ff <= stop_seen_in;
      end
   end

endmodule

// ===== hdl/key_debounce_autorepeat_queue_unit.sv =====
// Top level of the keypad debouncer with typematic repeat and code queue.
// Depends on kdaq_pkg, kdaq_keyfsm and kdaq_queue.
//
// Each request beat is a tick that samples seven active-low key lines, a pop
// that takes one key code from the queue (zero when it is empty), or a flush
// that empties the queue and clears the stop flag. Every request beat gives
// exactly one response beat with the popped code, the number of codes still
// waiting and the stop flag. A beat is captured in an input register; once the
// output register is free or drains, the phase machine and the queue update
// together in a single pass while the response goes into an output register,
// so the unit takes one beat per cycle when the response side is not stalled.
// The input and output registers decouple the two sides: a new request is taken
// while a finished response still waits. The configuration registers are
// debounce, initial delay and repeat periods in ticks; write them only while no
// request is in flight. Writes to an index beyond the three registers are
// ignored. Counters compare after they increment, so a period of zero acts as
// one.
module key_debounce_autorepeat_queue_unit
   import kdaq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [6:0] key_lines, [7] zero
   input  logic [KIND_W-1:0]    req_tuser,   // [1:0] req_type

   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,   // [2:0] popped_code, [5:3] queued_count,
                                             // [6] stop_flag, [7] zero

   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [TICKS_W-1:0]   csr_data
);

   // Configuration registers.
   cfg_type cfg_ff, cfg_in;

   // Input register.
   logic                in_valid_ff;
   logic [KIND_W-1:0]   in_kind_ff;
   logic [LINES_W-1:0]  in_lines_ff;

   // Output register.
   logic       rsp_valid_ff;
   logic [7:0] rsp_data_ff;

   logic          advance;
   logic          tick_en;
   queue_cmd_type cmd;
   offer_type     offer;
   status_type    status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEBOUNCE: cfg_in.debounce_ticks      = csr_data;
            CSR_DELAY:    cfg_in.initial_delay_ticks = csr_data;
            CSR_REPEAT:   cfg_in.repeat_ticks        = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   // The held beat moves on whenever the output register is free or drains.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      tick_en   = 1'b0;
      cmd.pop   = 1'b0;
      cmd.flush = 1'b0;
      unique case (in_kind_ff)
         REQ_TICK:  tick_en   = advance;
         REQ_POP:   cmd.pop   = advance;
         REQ_FLUSH: cmd.flush = advance;
         default:   tick_en   = 1'b0;
      endcase
   end

   kdaq_keyfsm u_keyfsm (
      .clock     (clock),
      .reset     (reset),
      .tick_en   (tick_en),
      .key_lines (in_lines_ff),
      .cfg       (cfg_ff),
      .offer     (offer)
   );

   kdaq_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .offer  (offer),
      .status (status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks      <= DEBOUNCE_RESET;
         cfg_ff.initial_delay_ticks <= DELAY_RESET;
         cfg_ff.repeat_ticks        <= REPEAT_RESET;
         in_valid_ff                <= 1'b0;
         rsp_valid_ff               <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff  <= req_tuser;
         in_lines_ff <= req_tdata[LINES_W-1:0];
      end
      if (advance) begin
         rsp_data_ff <= {1'b0, status.stop_flag, status.queued_count, status.popped_code};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== hdl/kdaq_checker.sv =====
// Port-level checks for the keypad debounce and repeat queue, bound to the top level.
// Depends on kdaq_pkg and key_debounce_autorepeat_queue_unit.
module kdaq_checker
   import kdaq_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_tready,
   input logic                 rsp_tvalid,
   input logic                 rsp_tready,
   input logic [7:0]           rsp_tdata
);

   // A stalled response beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response beat changed while stalled");

   // The queue never reports more codes than it can hold with one slot free.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (int'(rsp_tdata[5:3]) < QUEUE_SLOTS))
      else $error("queued count beyond queue capacity");

   // Padding bit of the response stays zero.
   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[7])
      else $error("response padding bit set");

   // Reset leaves no response pending and the input side open.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("unit not idle after reset");

endmodule

bind key_debounce_autorepeat_queue_unit kdaq_checker u_kdaq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== sim/key_debounce_autorepeat_queue_unit_tb.sv =====
// Self-checking testbench for key_debounce_autorepeat_queue_unit.
// Holds its own model of the key phase machine and code queue in a scoreboard class.
// Depends on kdaq_pkg and the unit itself.
`timescale 1ns / 1ps

module key_debounce_autorepeat_queue_unit_tb;
   import kdaq_pkg::*;

   localparam int HALF_PERIOD = 6;
   localparam int RESET_CYCLES = 10;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int DRAIN_CYCLES = 10;

   // Codes and line values used by the stimulus and the model.
   localparam logic [KIND_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [LINES_W-1:0] LINES_RELEASED = 7'h7F;
   localparam logic [LINES_W-1:0] LINES_ALL_DOWN = 7'h00;
   localparam int LINE_UP = 0;
   localparam int LINE_RUN = 2;
   localparam int LINE_D3 = 3;
   localparam int LINE_D2 = 4;
   localparam int LINE_D0 = 6;
   localparam code_type CODE_UP = 3'd5;
   localparam code_type CODE_DOWN = 3'd6;
   localparam code_type CODE_D3 = 3'd4;
   localparam code_type CODE_D2 = 3'd3;
   localparam code_type CODE_D1 = 3'd2;
   localparam code_type CODE_D0 = 3'd1;
   localparam code_type LINE_CODE [LINES_W] =
      '{CODE_UP, CODE_DOWN, CODE_RUN, CODE_D3, CODE_D2, CODE_D1, CODE_D0};

   // The scoreboard tracks the key machine and the queue beat by beat and keeps
   // the status that each accepted request should produce, oldest first.
   class keyq_status_checker;
      ticks_type debounce_period = DEBOUNCE_RESET;
      ticks_type delay_period = DELAY_RESET;
      ticks_type repeat_period = REPEAT_RESET;

      phase_type key_phase = PH_WAIT;
      code_type held_code = CODE_NONE;
      ticks_type settle_ticks = '0;
      ticks_type delay_cnt = '0;
      ticks_type autorep_ticks = '0;
      code_type slot_codes [QUEUE_SLOTS];
      int rd_slot = 0;
      int wr_slot = 0;
      logic stop_seen = 1'b0;

      status_type status_due [$];
      int mismatches = 0;
      int responses_seen = 0;

      function void set_register(logic [CSR_IDX_W-1:0] idx, ticks_type value);
         case (idx)
            CSR_DEBOUNCE: debounce_period = value;
            CSR_DELAY: delay_period = value;
            CSR_REPEAT: repeat_period = value;
            default: ;
         endcase
      endfunction

      function int pending();
         return status_due.size();
      endfunction

      function code_type line_code(logic [LINES_W-1:0] lines);
         for (int i = 0; i < LINES_W; i++) begin
            if (!lines[i]) return LINE_CODE[i];
         end
         return CODE_NONE;
      endfunction

      // The run key latches the stop flag even when the queue has no room.
      function void offer(code_type code);
         int nxt;
         if (code == CODE_RUN) stop_seen = 1'b1;
         nxt = (wr_slot + 1) % QUEUE_SLOTS;
         if (nxt == rd_slot) return;
         slot_codes[wr_slot] = code;
         wr_slot = nxt;
      endfunction

      // Counters are bumped before the compare, so a period of zero acts as one.
      function void advance_keys(logic [LINES_W-1:0] lines);
         code_type code;
         code = line_code(lines);
         case (key_phase)
            PH_WAIT: begin
               settle_ticks = '0;
               if (code != CODE_NONE) begin
                  held_code = code;
                  key_phase = PH_DEBOUNCE;
               end
            end
            PH_DEBOUNCE: begin
               if (code != held_code) begin
                  key_phase = PH_WAIT;
               end else begin
                  settle_ticks = settle_ticks + 8'd1;
                  if (settle_ticks >= debounce_period) begin
                     delay_cnt = '0;
                     key_phase = PH_DELAY;
                  end
               end
            end
            PH_DELAY: begin
               // Only a clean release during the initial delay is a short press.
               if (code != held_code) begin
                  if (code == CODE_NONE) offer(held_code);
                  key_phase = PH_WAIT;
               end else begin
                  delay_cnt = delay_cnt + 8'd1;
                  if (delay_cnt >= delay_period) begin
                     offer(held_code);
                     autorep_ticks = '0;
                     key_phase = PH_REPEAT;
                  end
               end
            end
            default: begin
               if (code != held_code) begin
                  key_phase = PH_WAIT;
               end else begin
                  autorep_ticks = autorep_ticks + 8'd1;
                  if (autorep_ticks >= repeat_period) begin
                     offer(held_code);
                     autorep_ticks = '0;
                  end
               end
            end
         endcase
      endfunction

      function void note_request(logic [KIND_W-1:0] kind, logic [LINES_W-1:0] lines);
         status_type s;
         code_type popped;
         popped = CODE_NONE;
         case (kind)
            REQ_TICK: advance_keys(lines);
            REQ_POP: begin
               if (rd_slot != wr_slot) begin
                  popped = slot_codes[rd_slot];
                  rd_slot = (rd_slot + 1) % QUEUE_SLOTS;
               end
            end
            REQ_FLUSH: begin
               rd_slot = wr_slot;
               stop_seen = 1'b0;
            end
            default: ;
         endcase
         s.popped_code = popped;
         s.queued_count = count_type'((wr_slot + QUEUE_SLOTS - rd_slot) % QUEUE_SLOTS);
         s.stop_flag = stop_seen;
         status_due.push_back(s);
      endfunction

      task report_mismatch(string what, int got, int want);
         $display("[%0t] response %0d: %s got %0d, want %0d",
                  $realtime, responses_seen, what, got, want);
         mismatches++;
      endtask

      task check_status(logic [7:0] data);
         status_type want;
         responses_seen++;
         if (status_due.size() == 0) begin
            report_mismatch("unrequested beat, tdata", data, 0);
            return;
         end
         want = status_due.pop_front();
         if (data[2:0] !== want.popped_code)
            report_mismatch("popped_code", data[2:0], want.popped_code);
         if (data[5:3] !== want.queued_count)
            report_mismatch("queued_count", data[5:3], want.queued_count);
         if (data[6] !== want.stop_flag)
            report_mismatch("stop_flag", data[6], want.stop_flag);
         if (data[7] !== 1'b0)
            report_mismatch("pad bit", data[7], 0);
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;
   logic [KIND_W-1:0] req_tuser;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [7:0] rsp_tdata;
   logic csr_valid;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TICKS_W-1:0] csr_data;

   keyq_status_checker chk = new;
   logic idling;        // random gaps on both sides while set
   logic quiet;         // last part of the run: gaps stay off
   logic long_hold;     // asks the response side for one long hold-off
   int beats_offered;   // accepted requests the unit acts on

   key_debounce_autorepeat_queue_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Hard stop well past the slowest legal run (every beat waiting out a full
   // sender gap and a full receiver stall, plus the long hold-off).
   initial begin
      #(5_000_000);
      $display("key_debounce_autorepeat_queue_unit test failed");
      $finish;
   end

   // Response side: ready changes on the falling edge only. Stalls come in
   // bursts, and once the main thread asks for it, ready stays low for a long
   // stretch so that both pipeline registers fill and req_tready drops.
   initial begin
      int stall;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_tready = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            long_hold = 1'b0;
         end else if (idling && $urandom_range(0, 7) == 0) begin
            stall = $urandom_range(1, 17);
            rsp_tready = 1'b0;
            repeat (stall - 1) @(negedge clock);
         end else begin
            rsp_tready = 1'b1;
         end
      end
   end

   // Every accepted response beat is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) chk.check_status(rsp_tdata);
   end

   // Offers one request beat, optionally after a random gap, and records it
   // at the edge where it is taken.
   task automatic send_beat(input logic [KIND_W-1:0] kind, input logic [LINES_W-1:0] lines);
      int gap;
      if (idling && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 17);
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tuser = kind;
      req_tdata = {1'b0, lines};
      do @(posedge clock); while (!req_tready);
      chk.note_request(kind, lines);
      if (kind != REQ_UNUSED) beats_offered++;
   endtask

   task automatic send_tick(input logic [LINES_W-1:0] lines);
      send_beat(REQ_TICK, lines);
   endtask

   task automatic send_pop();
      send_beat(REQ_POP, LINES_RELEASED);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input ticks_type value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      chk.set_register(idx, value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Registers change only with nothing in flight: drop valid, let every
   // expected status come back, then let the pipeline settle.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (chk.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_periods(input ticks_type dbc, input ticks_type dly, input ticks_type rep);
      wait_idle();
      write_csr(CSR_DEBOUNCE, dbc);
      write_csr(CSR_DELAY, dly);
      write_csr(CSR_REPEAT, rep);
   endtask

   // Lines for holding key line k: k is low, every line of higher priority is
   // high, and the lower-priority lines chatter at random without changing
   // the encoded code.
   function automatic logic [LINES_W-1:0] hold_lines(input int k);
      logic [LINES_W-1:0] v;
      v = LINES_W'($urandom);
      v = v | ((LINES_W'(1) << k) - LINES_W'(1));
      v[k] = 1'b0;
      return v;
   endfunction

   function automatic int eff_period(input ticks_type p);
      return (p == 0) ? 1 : int'(p);
   endfunction

   // Random traffic, mostly whole key presses: a little contact bounce, a hold
   // of random length with pops mixed in, then a release. Noise ticks,
   // flushes and unused request kinds are sprinkled between presses. A hold
   // never runs past what is left of the phase's beat budget.
   task automatic run_phase(input int n_beats);
      int target;
      int pick;
      int k;
      int span;
      int hold;
      target = beats_offered + n_beats;
      while (beats_offered < target) begin
         if (!quiet && $urandom_range(0, 7) == 0) idling = !idling;
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_tick(LINES_W'($urandom));
         end else if (pick < 10) begin
            send_beat(REQ_FLUSH, LINES_W'($urandom));
         end else if (pick < 12) begin
            send_beat(REQ_UNUSED, LINES_W'($urandom));
         end else if (pick < 18) begin
            repeat ($urandom_range(1, 4)) send_pop();
         end else begin
            k = $urandom_range(0, LINES_W - 1);
            span = eff_period(chk.debounce_period) + eff_period(chk.delay_period)
                   + 3 * eff_period(chk.repeat_period) + 4;
            if (span > 520) span = 520;
            hold = ($urandom_range(0, 1) == 0) ? $urandom_range(1, span)
                                               : $urandom_range(span / 2, span);
            if (hold > target - beats_offered) hold = target - beats_offered;
            repeat ($urandom_range(0, 2)) send_tick(LINES_W'($urandom));
            repeat (hold) begin
               send_tick(hold_lines(k));
               if ($urandom_range(0, 4) == 0) send_pop();
            end
            repeat ($urandom_range(1, 3)) send_tick(LINES_RELEASED);
            repeat ($urandom_range(0, 2)) send_pop();
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = REQ_TICK;
      csr_valid = 1'b0;
      csr_index = CSR_DEBOUNCE;
      csr_data = '0;
      idling = 1'b0;
      quiet = 1'b0;
      long_hold = 1'b0;
      beats_offered = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Short periods so the directed presses reach every phase quickly; the
      // write to the unused index must leave all three registers alone.
      set_periods(8'd1, 8'd2, 8'd1);
      write_csr(CSR_UNUSED, 8'd0);

      // Pop on an empty queue, then a request kind the unit does not use.
      send_pop();
      send_beat(REQ_UNUSED, LINES_ALL_DOWN);
      // Every line low: the up key wins; a release in the delay phase is a short press.
      send_tick(LINES_ALL_DOWN);
      send_tick(LINES_ALL_DOWN);
      send_tick(LINES_RELEASED);
      // Run key held through the initial delay and one repeat, which sets the stop
      // flag; a release from the repeat phase enqueues nothing.
      repeat (5) send_tick(~(LINES_W'(1) << LINE_RUN));
      send_tick(LINES_RELEASED);
      // d0 held until the queue is full, so the last repeat is dropped.
      repeat (6) send_tick(~(LINES_W'(1) << LINE_D0));
      send_tick(LINES_RELEASED);
      // A code change during debounce falls back to waiting without a press.
      send_tick(~(LINES_W'(1) << LINE_D3));
      send_tick(~(LINES_W'(1) << LINE_D2));
      send_tick(LINES_RELEASED);
      send_pop();
      send_pop();
      // Flush a non-empty queue with the stop flag set, then pop it empty.
      send_beat(REQ_FLUSH, LINES_RELEASED);
      send_pop();
      send_tick(~(LINES_W'(1) << LINE_UP));

      idling = 1'b1;
      set_periods(8'd0, 8'd0, 8'd0);
      run_phase(150);

      // Reset values again; the response side holds off for a long while
      // right away so the request side backs up.
      set_periods(DEBOUNCE_RESET, DELAY_RESET, REPEAT_RESET);
      long_hold = 1'b1;
      run_phase(200);

      set_periods(8'd2, 8'd5, 8'd3);
      run_phase(250);

      set_periods(8'd255, 8'd1, 8'd2);
      run_phase(250);

      // Last stretch runs back to back with no gaps on either side.
      quiet = 1'b1;
      idling = 1'b0;
      set_periods(8'd1, 8'd255, 8'd255);
      run_phase(275);

      @(negedge clock);
      req_tvalid = 1'b0;
      while (chk.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (chk.mismatches == 0) begin
         $display("key_debounce_autorepeat_queue_unit test passed");
      end else begin
         $display("key_debounce_autorepeat_queue_unit test failed");
      end
      $finish;
   end

endmodule
